// ===== hw/rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and helpers for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // decoded control bytes
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // run queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'd0,
    MODE_ESC     = 4'd1,
    MODE_HEX     = 4'd2,
    MODE_SUR_BS  = 4'd3,
    MODE_SUR_U   = 4'd4,
    MODE_SUR_HEX = 4'd5,
    MODE_DRAIN   = 4'd6
  } mode_t;

  // one run of 1 to 4 results caused by a single input byte
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [1:0]      kind;
    logic [3:0][7:0] data;
  } run_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic run_t utf8_run(input logic [20:0] cp);
    run_t r;
    r.kind = KIND_DATA;
    r.data = '0;
    if (cp < 21'h00080) begin
      r.last_idx = 2'd0;
      r.data[0]  = cp[7:0];
    end else if (cp < 21'h00800) begin
      r.last_idx = 2'd1;
      r.data[0]  = {3'b110, cp[10:6]};
      r.data[1]  = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.last_idx = 2'd2;
      r.data[0]  = {4'b1110, cp[15:12]};
      r.data[1]  = {2'b10, cp[11:6]};
      r.data[2]  = {2'b10, cp[5:0]};
    end else begin
      r.last_idx = 2'd3;
      r.data[0]  = {5'b11110, cp[20:18]};
      r.data[1]  = {2'b10, cp[17:12]};
      r.data[2]  = {2'b10, cp[11:6]};
      r.data[3]  = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic run_t single_run(input logic [7:0] b, input logic [1:0] k);
    run_t r;
    r.last_idx = 2'd0;
    r.kind     = k;
    r.data     = '0;
    r.data[0]  = b;
    return r;
  endfunction

endpackage

// ===== hw/rtl/jsu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_queue
// small fifo of decoded runs between front and back
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  run_t      push_run,
  input  logic      pop,
  output run_t      head,
  output q_status_t status
);

  run_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/jsu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// takes escaped bytes, tracks escape state and builds result runs
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_byte,
  input  q_status_t q_status,
  output logic      push,
  output run_t      push_run
);

  mode_t       mode;
  mode_t       mode_next;
  logic [1:0]  digit_count;
  logic [1:0]  digit_count_next;
  logic [15:0] code_unit;
  logic [15:0] code_unit_next;
  logic [15:0] lead_unit;
  logic [15:0] lead_unit_next;

  logic        accept;
  logic        hex_ok;
  logic [3:0]  hex_nib;
  logic [15:0] cu_shift;
  logic        last_digit;
  logic        is_lead;
  logic        is_trail;
  logic [20:0] cp_pair;
  logic        esc_known;
  logic [7:0]  esc_byte;
  logic        fail;
  logic        emit;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  // classify the byte against the current mode
  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'h0;
    case (in_byte) inside
      [8'h30:8'h39]: hex_nib = 4'(in_byte - 8'h30);
      [8'h61:8'h66]: hex_nib = 4'(in_byte - 8'h57);
      [8'h41:8'h46]: hex_nib = 4'(in_byte - 8'h37);
      default:       hex_ok  = 1'b0;
    endcase

    cu_shift   = {code_unit[11:0], hex_nib};
    last_digit = (digit_count == 2'd3);
    is_lead    = (cu_shift inside {[16'hD800:16'hDBFF]});
    is_trail   = (cu_shift inside {[16'hDC00:16'hDFFF]});
    cp_pair    = {1'b0, lead_unit[9:0], cu_shift[9:0]} + 21'h10000;

    esc_known = 1'b1;
    esc_byte  = in_byte;
    case (in_byte)
      CH_QUOTE, CH_BSLASH, CH_SLASH, CH_U: esc_byte = in_byte;
      CH_B:    esc_byte = CTL_BS;
      CH_F:    esc_byte = CTL_FF;
      CH_N:    esc_byte = CTL_LF;
      CH_R:    esc_byte = CTL_CR;
      CH_T:    esc_byte = CTL_HT;
      default: esc_known = 1'b0;
    endcase

    case (mode)
      MODE_ESC:     fail = !esc_known;
      MODE_HEX:     fail = !hex_ok ||
                           (last_digit && !is_lead && (is_trail || cu_shift == 16'h0000));
      MODE_SUR_HEX: fail = !hex_ok || (last_digit && !is_trail);
      MODE_SUR_BS:  fail = (in_byte != CH_BSLASH);
      MODE_SUR_U:   fail = (in_byte != CH_U);
      default:      fail = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    code_unit_next   = code_unit;
    lead_unit_next   = lead_unit;
    case (mode)
      MODE_ESC: begin
        mode_next = MODE_NORMAL;
        if (in_byte == CH_U) begin
          mode_next        = MODE_HEX;
          digit_count_next = 2'd0;
          code_unit_next   = 16'h0000;
        end
      end
      MODE_HEX, MODE_SUR_HEX: begin
        if (hex_ok) begin
          code_unit_next   = cu_shift;
          digit_count_next = digit_count + 2'd1;
          if (last_digit) begin
            if (mode == MODE_HEX && is_lead) begin
              lead_unit_next = cu_shift;
              mode_next      = MODE_SUR_BS;
            end else begin
              mode_next = MODE_NORMAL;
            end
          end
        end
      end
      MODE_SUR_BS: begin
        mode_next = MODE_SUR_U;
      end
      MODE_SUR_U: begin
        mode_next        = MODE_SUR_HEX;
        digit_count_next = 2'd0;
        code_unit_next   = 16'h0000;
      end
      MODE_DRAIN: begin
        if (in_byte == CH_NUL) begin
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        mode_next = (in_byte == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
      end
    endcase
    if (fail) begin
      mode_next = (in_byte == CH_NUL) ? MODE_NORMAL : MODE_DRAIN;
    end
  end

  // run built for this byte
  always_comb begin
    emit     = 1'b0;
    push_run = single_run(CH_NUL, KIND_DATA);
    if (fail) begin
      emit     = 1'b1;
      push_run = single_run(CH_NUL, KIND_ERR);
    end else begin
      case (mode)
        MODE_ESC: begin
          emit     = (in_byte != CH_U);
          push_run = single_run(esc_byte, KIND_DATA);
        end
        MODE_HEX: begin
          emit     = last_digit && !is_lead;
          push_run = utf8_run({5'b00000, cu_shift});
        end
        MODE_SUR_HEX: begin
          emit     = last_digit;
          push_run = utf8_run(cp_pair);
        end
        MODE_SUR_BS, MODE_SUR_U, MODE_DRAIN: begin
          emit = 1'b0;
        end
        default: begin
          emit     = (in_byte != CH_BSLASH);
          push_run = (in_byte == CH_NUL) ? single_run(CH_NUL, KIND_END)
                                         : single_run(in_byte, KIND_DATA);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      digit_count <= 2'd0;
      code_unit   <= 16'h0000;
      lead_unit   <= 16'h0000;
    end else if (accept) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      code_unit   <= code_unit_next;
      lead_unit   <= lead_unit_next;
    end
  end

endmodule

// ===== hw/rtl/jsu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// walks each queued run, one result per cycle into a register unless stalled
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  q_status,
  input  run_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last_of_run
);

  logic [1:0] idx;
  logic       load;
  logic       take;
  logic       at_last;

  assign load    = !out_valid || out_ready;
  assign take    = load && !q_status.empty;
  assign at_last = (idx == head.last_idx);
  assign pop     = take && at_last;

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte    <= head.data[idx];
      kind        <= head.kind;
      last_of_run <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= !q_status.empty;
      end
      if (take) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// path: an accepted byte's run is written into the run queue, then loaded into the output
//   register; a result waits longer while earlier results are still queued or the output is stalled
// throughput: one result per cycle out of the output register while out_ready is high; a byte
//   that decodes to a multi-byte utf-8 sequence holds the back end until each of its bytes is
//   driven, the front keeps taking bytes until the 4-entry run queue fills
// reset: synchronous rst puts the decoder in normal text mode and empties queue and output
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// json string body unescaper with utf-8 output, decoupled front and back
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // escaped text requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  // decoded results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last_of_run
);

  // front to queue
  logic      push;
  run_t      push_run;
  // queue to back
  logic      pop;
  run_t      head;
  q_status_t q_status;

  // front: escape state machine, hex collection, surrogate pairing and utf-8 encode,
  // one input byte per cycle whenever the queue has room
  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_status (q_status),
    .push     (push),
    .push_run (push_run)
  );

  // queue of whole runs, lets a stalled output side leave the input side running
  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // back: steps through the bytes of the head run into the output register
  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .kind        (kind),
    .last_of_run (last_of_run)
  );

endmodule
